### sv/krd_pkg.sv
package krd_pkg;

  localparam int DEF_PACKET_EVENTS  = 8;
  localparam int DEF_KEY_TABLE_SIZE = 1024;
  localparam int DEF_PENDING_DEPTH  = 8;

  localparam logic [15:0] RESET_DELAY_TICKS = 16'd12;
  localparam logic [19:0] RESET_SHIFT_US    = 20'd12000;
  localparam logic [20:0] USEC_PER_SEC      = 21'd1000000;
  localparam logic [20:0] USEC_TWO_SEC      = 21'd2000000;

  localparam logic [1:0]  KEY_RELEASED = 2'd0;
  localparam logic [1:0]  KEY_DELAYING = 2'd3;
  localparam logic [15:0] EV_TYPE_SYNC = 16'd0;
  localparam logic [15:0] EV_TYPE_KEY  = 16'd1;

  typedef enum logic {
    REG_RELEASE_DELAY = 1'b0,
    REG_TS_SHIFT      = 1'b1
  } reg_idx_t;

  // packed so that ev_type sits in the lowest bits
  typedef struct packed {
    logic [19:0] usec;
    logic [31:0] sec;
    logic [31:0] value;
    logic [15:0] code;
    logic [15:0] ev_type;
  } ev_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY,
    ST_TICK_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

### sv/key_release_debouncer.sv
// Key release debouncer. Events collect into a packet until a sync event
// closes it; the packet is then scanned one event per cycle, key events update
// a per-key state table, and the first release of a tracked key parks the
// packet in a pending queue, when the queue has room, instead of emitting it.
// A packet that is not parked is sent out at once. Each tick beat
// (tuser = 1) advances the tick counter and pops at most one expired entry;
// if its key is still delaying, the packet is replayed with timestamps moved
// by shift_us (tuser on the output marks replays). A sync beat is scanned,
// then either copied into the pending memory or emitted beat by beat, each
// beat read and then loaded into the output register, waiting while the
// output stalls; an expiring tick reads the key table first and, if the key
// is still delaying, replays the packet the same way. The packet scan and
// the single-ported pending memory set this sequence. After reset the key
// table is cleared, during which no beat is taken; configuration writes are
// taken at any time.
module key_release_debouncer #(
  parameter int PACKET_EVENTS  = krd_pkg::DEF_PACKET_EVENTS,
  parameter int KEY_TABLE_SIZE = krd_pkg::DEF_KEY_TABLE_SIZE,
  parameter int PENDING_DEPTH  = krd_pkg::DEF_PENDING_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  // config write port
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [19:0]   cfg_wdata,
  // input stream
  input  logic          s_tvalid,
  output logic          s_tready,
  // ev_type[15:0], ev_code[31:16], ev_value[63:32], time_sec[95:64],
  // time_usec[115:96], zero pad
  input  logic [119:0]  s_tdata,
  // mode: 0 event, 1 tick
  input  logic          s_tuser,
  // output stream
  output logic          m_tvalid,
  input  logic          m_tready,
  // out_type[15:0], out_code[31:16], out_value[63:32], out_sec[95:64],
  // out_usec[115:96], zero pad
  output logic [119:0]  m_tdata,
  // was_delayed
  output logic          m_tuser,
  // last_of_packet
  output logic          m_tlast
);
  import krd_pkg::*;

  localparam int IW  = $clog2(PACKET_EVENTS);
  localparam int CW  = $clog2(PACKET_EVENTS + 1);
  localparam int KW  = $clog2(KEY_TABLE_SIZE);
  localparam int SW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int FW  = $clog2(PENDING_DEPTH + 1);
  localparam int PMD = PENDING_DEPTH * PACKET_EVENTS;
  localparam int AW  = (PMD > 1) ? $clog2(PMD) : 1;

  state_t state, state_next;

  // config registers
  logic [15:0] delay_ticks;
  logic [19:0] shift_us;

  // packet buffer
  ev_t         pkt [PACKET_EVENTS];
  logic [IW-1:0] pkt_cnt;

  // pending queue bookkeeping
  logic [CW-1:0] pcount [PENDING_DEPTH];
  logic [KW-1:0] pkey   [PENDING_DEPTH];
  logic [31:0]   pdl    [PENDING_DEPTH];
  logic [SW-1:0] head, tail, slot;
  logic [FW-1:0] fill;
  logic [31:0]   tick;

  // sequencer
  logic [IW-1:0] cnt;
  logic [CW-1:0] n_cur;
  logic          delayed;

  ev_t   in_ev, scan_ev, pend_rd, shifted;
  logic  accept, is_sync, expire, key_hit, can_queue, last_scan, out_free, last_emit;
  logic [31:0] tick_inc, age;
  logic  kt_we, kt_busy;
  logic [KW-1:0] kt_waddr;
  logic [1:0]    kt_wdata, kt_rdata;
  logic [AW-1:0] pend_addr;

  assign in_ev    = ev_t'(s_tdata[115:0]);
  assign s_tready = (state == ST_IDLE) && !kt_busy;
  assign accept   = s_tvalid && s_tready;
  assign is_sync  = (in_ev.ev_type == EV_TYPE_SYNC) && (in_ev.code == 16'd0) &&
                    (in_ev.value == 32'd0);

  // tick counter increments before the head deadline test
  assign tick_inc = tick + 32'd1;
  assign age      = tick_inc - pdl[head];
  assign expire   = (fill != '0) && !age[31];

  assign scan_ev   = pkt[cnt];
  assign key_hit   = (scan_ev.ev_type == EV_TYPE_KEY) &&
                     ({1'b0, scan_ev.code} < 17'(KEY_TABLE_SIZE));
  assign can_queue = (fill < FW'(PENDING_DEPTH));
  assign last_scan = (CW'(cnt) + 1'b1) == n_cur;
  assign last_emit = last_scan;
  assign out_free  = !m_tvalid || m_tready;

  assign pend_addr = AW'(int'(slot) * PACKET_EVENTS + int'(cnt));

  always_comb begin
    kt_we    = 1'b0;
    kt_waddr = scan_ev.code[KW-1:0];
    kt_wdata = scan_ev.value[1:0];
    if (state == ST_SCAN && key_hit) begin
      kt_we = 1'b1;
      if (scan_ev.value == 32'd0) kt_wdata = can_queue ? KEY_DELAYING : KEY_RELEASED;
    end else if (state == ST_TICK_CHK && kt_rdata == KEY_DELAYING) begin
      kt_we    = 1'b1;
      kt_waddr = pkey[slot];
      kt_wdata = KEY_RELEASED;
    end
  end

  krd_keytab #(.KEY_TABLE_SIZE(KEY_TABLE_SIZE), .KW(KW)) u_keytab (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (kt_we),
    .wr_addr (kt_waddr),
    .wr_data (kt_wdata),
    .rd_addr (pkey[head]),
    .rd_data (kt_rdata),
    .busy    (kt_busy)
  );

  krd_pend #(.DEPTH(PMD), .AW(AW)) u_pend (
    .clk     (clk),
    .wr_en   (state == ST_COPY),
    .wr_addr (pend_addr),
    .wr_data (pkt[cnt]),
    .rd_addr (pend_addr),
    .rd_data (pend_rd)
  );

  krd_tshift u_tshift (
    .ev_in    (pend_rd),
    .shift_us (shift_us),
    .ev_out   (shifted)
  );

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= RESET_DELAY_TICKS;
      shift_us    <= RESET_SHIFT_US;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_RELEASE_DELAY: delay_ticks <= cfg_wdata[15:0];
        REG_TS_SHIFT:      shift_us    <= cfg_wdata;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser) begin
            if (expire) state_next = ST_TICK_CHK;
          end else if (is_sync) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (key_hit && scan_ev.value == 32'd0 && can_queue) state_next = ST_COPY;
        else if (last_scan) state_next = ST_EMIT_RD;
      end
      ST_COPY: begin
        if (cnt == IW'(PACKET_EVENTS - 1)) state_next = ST_IDLE;
      end
      ST_TICK_CHK: begin
        state_next = (kt_rdata == KEY_DELAYING) ? ST_EMIT_RD : ST_IDLE;
      end
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) state_next = last_emit ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_cnt <= '0;
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      tick    <= '0;
      cnt     <= '0;
      n_cur   <= '0;
      slot    <= '0;
      delayed <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              tick <= tick_inc;
              if (expire) begin
                slot <= head;
                head <= (head == SW'(PENDING_DEPTH - 1)) ? '0 : head + 1'b1;
                fill <= fill - 1'b1;
              end
            end else if (is_sync) begin
              n_cur   <= CW'(pkt_cnt) + 1'b1;
              pkt_cnt <= '0;
              cnt     <= '0;
            end else if (pkt_cnt != IW'(PACKET_EVENTS - 1)) begin
              pkt_cnt <= pkt_cnt + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (key_hit && scan_ev.value == 32'd0 && can_queue) begin
            slot <= tail;
            tail <= (tail == SW'(PENDING_DEPTH - 1)) ? '0 : tail + 1'b1;
            fill <= fill + 1'b1;
            cnt  <= '0;
          end else if (last_scan) begin
            cnt     <= '0;
            delayed <= 1'b0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_COPY: cnt <= cnt + 1'b1;
        ST_TICK_CHK: begin
          n_cur   <= pcount[slot];
          cnt     <= '0;
          delayed <= 1'b1;
        end
        ST_EMIT_LD: begin
          if (out_free && !last_emit) cnt <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && !s_tuser &&
        (is_sync || pkt_cnt != IW'(PACKET_EVENTS - 1))) begin
      pkt[pkt_cnt] <= in_ev;
    end
    if (state == ST_SCAN && key_hit && scan_ev.value == 32'd0 && can_queue) begin
      pcount[tail] <= n_cur;
      pkey[tail]   <= scan_ev.code[KW-1:0];
      pdl[tail]    <= tick + {16'd0, delay_ticks};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT_LD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD && out_free) begin
      m_tdata <= {4'd0, delayed ? shifted : pkt[cnt]};
      m_tuser <= delayed;
      m_tlast <= last_emit;
    end
  end

endmodule

### sv/krd_keytab.sv
module krd_keytab #(
  parameter int KEY_TABLE_SIZE = 1024,
  parameter int KW = $clog2(KEY_TABLE_SIZE)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [KW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  input  logic [KW-1:0] rd_addr,
  output logic [1:0]    rd_data,
  output logic          busy
);
  import krd_pkg::*;

  logic [1:0]    mem [KEY_TABLE_SIZE];
  logic [KW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == KW'(KEY_TABLE_SIZE - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= KEY_RELEASED;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/krd_pend.sv
module krd_pend #(
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  krd_pkg::ev_t   wr_data,
  input  logic [AW-1:0]  rd_addr,
  output krd_pkg::ev_t   rd_data
);
  import krd_pkg::*;

  ev_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/krd_tshift.sv
module krd_tshift (
  input  krd_pkg::ev_t  ev_in,
  input  logic [19:0]   shift_us,
  output krd_pkg::ev_t  ev_out
);
  import krd_pkg::*;

  logic [20:0] sum;

  // sum stays below three seconds, so at most two carries
  always_comb begin
    sum    = {1'b0, ev_in.usec} + {1'b0, shift_us};
    ev_out = ev_in;
    if (sum >= USEC_TWO_SEC) begin
      ev_out.usec = 20'(sum - USEC_TWO_SEC);
      ev_out.sec  = ev_in.sec + 32'd2;
    end else if (sum >= USEC_PER_SEC) begin
      ev_out.usec = 20'(sum - USEC_PER_SEC);
      ev_out.sec  = ev_in.sec + 32'd1;
    end else begin
      ev_out.usec = sum[19:0];
    end
  end

endmodule

### tb/key_release_debouncer_tb.sv
`timescale 1ns / 100ps

module key_release_debouncer_tb;
  import krd_pkg::*;

  localparam int NPKT = 8;
  localparam int NKEY = 1024;
  localparam int NPEND = 8;
  localparam int WATCHDOG_LIMIT = 6000; // outlasts the key table clear
  localparam int SETTLE_CYCLES = 60;    // longest sync or replay walk, padded
  localparam bit BEAT_EVENT = 1'b0;
  localparam bit BEAT_TICK = 1'b1;

  typedef struct {
    bit  tick;
    ev_t ev;
  } beat_t;

  typedef struct {
    ev_t ev;
    bit  delayed;
    bit  last;
  } out_beat_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  reg_idx_t     cfg_addr;
  logic [19:0]  cfg_wdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  key_release_debouncer u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // beats waiting to be sent, and output beats the shadow model predicts
  beat_t     send_q[$];
  out_beat_t emit_q[$];
  beat_t     cur_beat;
  int        src_idle_pct;
  int        snk_stall_pct;
  int        mismatches;
  int        quiet_cycles;

  // shadow state of the debouncer
  logic [15:0] delay_ticks;
  logic [19:0] shift_us;
  ev_t         pkt[NPKT];
  int          pkt_n;
  logic [1:0]  key_state[NKEY];
  ev_t         park_ev[NPEND][NPKT];
  int          park_n[NPEND];
  int          park_key[NPEND];
  logic [31:0] park_deadline[NPEND];
  int          q_head, q_tail, q_fill;
  logic [31:0] tick_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow model: one accepted input beat in, predicted output beats queued
  // ---------------------------------------------------------------------------
  function automatic void push_packet(input ev_t evs[NPKT], input int n, input bit delayed);
    out_beat_t o;
    for (int i = 0; i < n; i++) begin
      o.ev = evs[i];
      o.delayed = delayed;
      o.last = (i == n - 1);
      emit_q.push_back(o);
    end
  endfunction

  function automatic void replay_tick();
    int slot;
    int key;
    ev_t evs[NPKT];
    logic [31:0] us;
    logic [31:0] diff;
    tick_count = tick_count + 32'd1;
    if (q_fill == 0) return;
    slot = q_head;
    diff = tick_count - park_deadline[slot];
    if (diff[31]) return; // head not expired yet
    q_head = (q_head + 1) % NPEND;
    q_fill--;
    key = park_key[slot];
    if (key_state[key] != KEY_DELAYING) return; // key pressed again: drop
    key_state[key] = KEY_RELEASED;
    for (int i = 0; i < park_n[slot]; i++) begin
      evs[i] = park_ev[slot][i];
      us = 32'(evs[i].usec) + 32'(shift_us);
      while (us >= 32'd1000000) begin
        us = us - 32'd1000000;
        evs[i].sec = evs[i].sec + 32'd1;
      end
      evs[i].usec = us[19:0];
    end
    push_packet(evs, park_n[slot], 1'b1);
  endfunction

  function automatic void close_packet();
    int n;
    ev_t e;
    n = pkt_n;
    pkt_n = 0;
    for (int i = 0; i < n; i++) begin
      e = pkt[i];
      if (e.ev_type != EV_TYPE_KEY || e.code >= NKEY) continue;
      if (e.value == 32'd0) begin
        if (q_fill < NPEND) begin
          key_state[e.code] = KEY_DELAYING;
          park_ev[q_tail] = pkt;
          park_n[q_tail] = n;
          park_key[q_tail] = e.code;
          park_deadline[q_tail] = tick_count + 32'(delay_ticks);
          q_tail = (q_tail + 1) % NPEND;
          q_fill++;
          return;
        end
        key_state[e.code] = KEY_RELEASED; // queue full: let it through
      end else begin
        key_state[e.code] = e.value[1:0];
      end
    end
    push_packet(pkt, n, 1'b0);
  endfunction

  function automatic void debounce_beat(input beat_t b);
    bit is_sync;
    if (b.tick) begin
      replay_tick();
      return;
    end
    is_sync = (b.ev.ev_type == EV_TYPE_SYNC && b.ev.code == 16'd0 && b.ev.value == 32'd0);
    if (!is_sync) begin
      if (pkt_n < NPKT - 1) begin
        pkt[pkt_n] = b.ev;
        pkt_n++;
      end
      return;
    end
    pkt[pkt_n] = b.ev;
    pkt_n++;
    close_packet();
  endfunction

  // ---------------------------------------------------------------------------
  // driver: input beats from send_q, random idle cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit    take;
    beat_t nb;
    if (!rst) begin
      if (s_tvalid && s_tready) debounce_beat(cur_beat);
      if (!s_tvalid || s_tready) begin
        take = (send_q.size() != 0) && ($urandom_range(0, 99) >= src_idle_pct);
        if (take) begin
          nb = send_q.pop_front();
          cur_beat <= nb;
          s_tdata <= {4'b0, nb.ev};
          s_tuser <= nb.tick;
        end
        s_tvalid <= take;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare output beats with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t exp_b;
    ev_t       got;
    if (!rst) begin
      m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      if (m_tvalid && m_tready) begin
        got = m_tdata[115:0];
        if (emit_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output beat: %h user %b last %b", got, m_tuser, m_tlast);
        end else begin
          exp_b = emit_q.pop_front();
          if (got !== exp_b.ev || m_tuser !== exp_b.delayed || m_tlast !== exp_b.last ||
              m_tdata[119:116] !== 4'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h d%b l%b  got %h d%b l%b", exp_b.ev, exp_b.delayed,
                       exp_b.last, got, m_tuser, m_tlast);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // microseconds sometimes above one second, to reach the double carry
  function automatic ev_t make_ev(input logic [15:0] t, input logic [15:0] c,
                                  input logic [31:0] v);
    ev_t e;
    int  r;
    r = $urandom_range(0, 9);
    e.ev_type = t;
    e.code = c;
    e.value = v;
    e.sec = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
    if (r < 2) e.usec = 20'd999999;
    else if (r < 4) e.usec = 20'($urandom_range(1000000, 1048575));
    else e.usec = 20'($urandom_range(0, 999999));
    return e;
  endfunction

  function automatic void add_ev(input logic [15:0] t, input logic [15:0] c,
                                 input logic [31:0] v);
    beat_t b;
    b.tick = BEAT_EVENT;
    b.ev = make_ev(t, c, v);
    send_q.push_back(b);
  endfunction

  function automatic void add_sync();
    add_ev(EV_TYPE_SYNC, 16'd0, 32'd0);
  endfunction

  function automatic void add_ticks(input int n);
    beat_t b;
    for (int i = 0; i < n; i++) begin
      b.tick = BEAT_TICK;
      b.ev = make_ev($urandom, $urandom, $urandom); // ignored on a tick
      send_q.push_back(b);
    end
  endfunction

  function automatic logic [15:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 7));
    if (r < 80) return $urandom_range(0, 1) ? 16'd1023 : 16'd1024;
    if (r < 92) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 32'd0;
    if (r < 70) return 32'd1;
    if (r < 85) return 32'd2;
    if (r < 92) return 32'd3;
    return $urandom;
  endfunction

  // mostly well-formed packets followed by ticks, the rest noise
  task automatic add_random(input int n_items);
    int start;
    int r;
    start = send_q.size();
    while (send_q.size() - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        repeat ($urandom_range(1, 3)) add_ev(EV_TYPE_KEY, pick_code(), pick_value());
        add_sync();
        add_ticks($urandom_range(0, 4));
      end else if (r < 80) begin
        repeat ($urandom_range(7, 10)) add_ev(EV_TYPE_KEY, pick_code(), pick_value());
        add_sync();
      end else if (r < 90) begin
        add_ev($urandom, $urandom, $urandom);
        if ($urandom_range(0, 1)) add_sync();
      end else begin
        add_ticks($urandom_range(1, 8));
      end
    end
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_RELEASE_DELAY) delay_ticks = val[15:0];
    else shift_us = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds until every predicted beat has come out, then lets the
  // block finish any silent work before the next register write
  task automatic drain();
    wait (send_q.size() == 0 && !s_tvalid && emit_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int src, input int snk, input logic [15:0] dly,
                           input logic [19:0] sh, input int n_items);
    drain();
    src_idle_pct = src;
    snk_stall_pct = snk;
    cfg_write(REG_RELEASE_DELAY, 20'(dly));
    cfg_write(REG_TS_SHIFT, sh);
    add_random(n_items);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_RELEASE_DELAY;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    mismatches = 0;
    quiet_cycles = 0;
    delay_ticks = RESET_DELAY_TICKS;
    shift_us = RESET_SHIFT_US;
    pkt_n = 0;
    foreach (key_state[i]) key_state[i] = KEY_RELEASED;
    q_head = 0;
    q_tail = 0;
    q_fill = 0;
    tick_count = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    add_ev(EV_TYPE_KEY, 16'd5, 32'd1);           // press: passes at once
    add_sync();
    add_ev(EV_TYPE_KEY, 16'd5, 32'd0);           // release: parked
    add_ev(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);   // other type rides along
    add_sync();
    add_ev(EV_TYPE_KEY, 16'd1024, 32'd0);        // key beyond table: passes
    add_ev(EV_TYPE_KEY, 16'd1023, 32'd3);        // low bits 3 mark delaying
    add_sync();
    add_ev(EV_TYPE_SYNC, 16'd0, 32'd5);          // not a sync
    add_ev(EV_TYPE_SYNC, 16'd1, 32'h8000_0000);
    add_sync();
    add_ticks(13);                               // key 5 replayed
    repeat (9) add_ev(EV_TYPE_KEY, 16'd7, 32'd2); // overflow: two dropped
    add_sync();
    run_phase(0, 0, 16'd1, 20'd999999, 0);
    // queue-full: nine releases, eight parked, the ninth passes through
    for (int i = 0; i < 9; i++) begin
      add_ev(EV_TYPE_KEY, 16'(i), 32'd0);
      add_sync();
    end
    add_ev(EV_TYPE_KEY, 16'd0, 32'd1);           // pressed again: entry dropped
    add_sync();
    add_ticks(12);

    run_phase(80, 0, 16'd3, 20'd0, 70);
    run_phase(0, 80, 16'd1, 20'd999999, 70);
    run_phase(24, 24, 16'd2, 20'd500000, 70);
    run_phase(0, 0, 16'd65535, 20'd123456, 60);  // nothing parked here expires

    drain();
    if (mismatches == 0 && emit_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
